### src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helper functions of the multi-channel
// ESC pulse generator.
// ----------------------------------------------------------------------------
package esc_pkg;

    // channel and value geometry
    localparam int CHANNELS       = 6;
    localparam int TICKS_PER_UNIT = 8;
    localparam int MAX_VALUE      = 1000;
    localparam int PULSE_BASE     = 1000;

    localparam int CHAN_W = 16;
    localparam int VAL_W  = $clog2(MAX_VALUE + 1);
    localparam int REL_W  = 14;
    localparam int TICK_W = 16;
    localparam int PIN_W  = 6;
    localparam int N_W    = $clog2(CHANNELS + 1);

    localparam logic [REL_W-1:0] REL_MAX   = {REL_W{1'b1}};
    localparam logic [PIN_W-1:0] PIN_MASK  = 6'h3f;
    localparam logic [PIN_W-1:0] PINS_EXIST = PIN_W'((1 << CHANNELS) - 1) & PIN_MASK;

    // release walk: one step per cycle, enough for the longest chain
    localparam int WALK_STEPS = CHANNELS - 1;
    localparam int STEP_W     = $clog2(WALK_STEPS + 1);

    // channel count limits
    localparam logic [N_W-1:0] MIN_USED = N_W'(4);
    localparam logic [N_W-1:0] MAX_USED = N_W'(CHANNELS);

    // queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item modes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_EVERY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 3'd4;

    // configuration reset values
    localparam logic [15:0]      RST_FRAME_PERIOD = 16'd20000;
    localparam logic [7:0]       RST_SERVO_EVERY  = 8'd8;
    localparam logic [PIN_W-1:0] RST_SERVO_MASK   = '0;
    localparam logic [2:0]       RST_CHAN_COUNT   = 3'd4;
    localparam logic [9:0]       RST_MIN_GAP      = 10'd20;

    typedef struct packed {
        logic                     mode;
        logic signed [CHAN_W-1:0] chan_a;
        logic signed [CHAN_W-1:0] chan_b;
        logic signed [CHAN_W-1:0] chan_c;
        logic signed [CHAN_W-1:0] chan_d;
        logic signed [CHAN_W-1:0] chan_e;
        logic signed [CHAN_W-1:0] chan_f;
    } in_word_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             ready_res;
        logic             accepted;
    } out_word_t;

    typedef struct packed {
        logic [15:0]      frame_period;
        logic [7:0]       servo_every;
        logic [PIN_W-1:0] servo_mask;
        logic [2:0]       chan_count;
        logic [9:0]       min_gap;
    } cfg_t;

    // classified word held in the queue
    typedef struct packed {
        logic                               is_load;
        logic [CHANNELS-1:0][VAL_W-1:0]     vals;
    } q_entry_t;

    // clamp a signed channel value to 0..MAX_VALUE
    function automatic logic [VAL_W-1:0] clamp_chan(input logic signed [CHAN_W-1:0] raw);
        logic [VAL_W-1:0] res;
        if (raw < 0)
        begin
            res = '0;
        end
        else if (raw > CHAN_W'(MAX_VALUE))
        begin
            res = VAL_W'(MAX_VALUE);
        end
        else
        begin
            res = raw[VAL_W-1:0];
        end
        return res;
    endfunction

    // release tick for a walked value, saturated to the release width
    function automatic logic [REL_W-1:0] rel_time(input logic [VAL_W-1:0] v);
        logic [31:0] t;
        logic [REL_W-1:0] res;
        t = (32'(PULSE_BASE) + 32'(v)) * 32'(TICKS_PER_UNIT);
        if (t > 32'(REL_MAX))
        begin
            res = REL_MAX;
        end
        else
        begin
            res = t[REL_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Accepts input words, classifies them as tick or load and clamps the
// channel values before they enter the queue.
// ----------------------------------------------------------------------------
module esc_front (
    input  esc_pkg::in_word_t  in_word,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               q_full,
    output logic               push_valid,
    output esc_pkg::q_entry_t  push_data
);

    // hold off the source while the queue is full
    assign in_stall   = q_full;
    assign push_valid = in_valid;

    // classify and clamp
    always_comb
    begin
        push_data.is_load = (in_word.mode == esc_pkg::MODE_LOAD);
        push_data.vals[0] = esc_pkg::clamp_chan(in_word.chan_a);
        push_data.vals[1] = esc_pkg::clamp_chan(in_word.chan_b);
        push_data.vals[2] = esc_pkg::clamp_chan(in_word.chan_c);
        push_data.vals[3] = esc_pkg::clamp_chan(in_word.chan_d);
        push_data.vals[4] = esc_pkg::clamp_chan(in_word.chan_e);
        push_data.vals[5] = esc_pkg::clamp_chan(in_word.chan_f);
    end

endmodule

### src/esc_queue.sv
// ----------------------------------------------------------------------------
// esc_queue
// Short queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module esc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  esc_pkg::q_entry_t  push_data,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output esc_pkg::q_entry_t  pop_data
);

    esc_pkg::q_entry_t                   entry_reg [esc_pkg::QUEUE_DEPTH];
    logic [esc_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [esc_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [esc_pkg::QCNT_W-1:0]          count_reg, count_next;
    logic                                push;
    logic                                do_pop;

    assign full      = (count_reg == esc_pkg::QCNT_W'(esc_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign push      = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == esc_pkg::QPTR_W'(esc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == esc_pkg::QPTR_W'(esc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Executes ticks and loads: pin levels, frame timing, and the release
// walk that follows each accepted load.
// ----------------------------------------------------------------------------
module esc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  esc_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  esc_pkg::q_entry_t  q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output esc_pkg::out_word_t out_word
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                                    state_reg, state_next;
    logic [esc_pkg::STEP_W-1:0]                step_reg, step_next;
    logic [esc_pkg::TICK_W-1:0]                tick_reg, tick_next;
    logic [esc_pkg::REL_W-1:0]                 rel_reg  [esc_pkg::CHANNELS];
    logic [esc_pkg::REL_W-1:0]                 rel_next [esc_pkg::CHANNELS];
    logic [esc_pkg::PIN_W-1:0]                 pin_reg, pin_next;
    logic                                      ready_reg, ready_next;
    logic [7:0]                                frames_reg, frames_next;
    logic [esc_pkg::N_W-1:0]                   nused_reg, nused_next;
    logic [esc_pkg::VAL_W-1:0]                 walk_val_reg  [esc_pkg::CHANNELS];
    logic [esc_pkg::VAL_W-1:0]                 walk_val_next [esc_pkg::CHANNELS];
    logic [esc_pkg::VAL_W-1:0]                 walk_rel_reg  [esc_pkg::CHANNELS];
    logic [esc_pkg::VAL_W-1:0]                 walk_rel_next [esc_pkg::CHANNELS];
    logic                                      out_valid_reg, out_valid_next;
    esc_pkg::out_word_t                        out_word_reg, out_word_next;

    logic [esc_pkg::VAL_W-1:0]                 cand_max   [esc_pkg::CHANNELS];
    logic                                      cand_found [esc_pkg::CHANNELS];
    logic [esc_pkg::VAL_W-1:0]                 walk_gap   [esc_pkg::CHANNELS];
    logic [esc_pkg::VAL_W-1:0]                 step_rel   [esc_pkg::CHANNELS];
    logic [esc_pkg::N_W-1:0]                   nused_cfg;
    logic [esc_pkg::TICK_W-1:0]                tick_inc;
    logic [7:0]                                frames_dec;
    logic                                      pop;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign q_pop     = pop;

    // take the next word when idle and the output register is free
    assign pop = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || !out_stall);

    // channels in use, limited to the supported range
    always_comb
    begin
        if (esc_pkg::N_W'(cfg.chan_count) < esc_pkg::MIN_USED)
        begin
            nused_cfg = esc_pkg::MIN_USED;
        end
        else if (esc_pkg::N_W'(cfg.chan_count) > esc_pkg::MAX_USED)
        begin
            nused_cfg = esc_pkg::MAX_USED;
        end
        else
        begin
            nused_cfg = esc_pkg::N_W'(cfg.chan_count);
        end
    end

    // one walk step per channel: move to the next smaller value if close enough
    always_comb
    begin
        for (int c = 0; c < esc_pkg::CHANNELS; c++)
        begin
            cand_max[c]   = '0;
            cand_found[c] = 1'b0;
            for (int j = 0; j < esc_pkg::CHANNELS; j++)
            begin
                if ((esc_pkg::N_W'(j) < nused_reg)
                    && (walk_val_reg[j] < walk_rel_reg[c])
                    && (!cand_found[c] || (walk_val_reg[j] > cand_max[c])))
                begin
                    cand_max[c]   = walk_val_reg[j];
                    cand_found[c] = 1'b1;
                end
            end
            walk_gap[c] = walk_rel_reg[c] - cand_max[c];
            step_rel[c] = (cand_found[c] && (walk_gap[c] < cfg.min_gap))
                          ? cand_max[c] : walk_rel_reg[c];
        end
    end

    assign tick_inc   = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
    assign frames_dec = frames_reg - 8'd1;

    // execution of ticks and loads
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        tick_next      = tick_reg;
        pin_next       = pin_reg;
        ready_next     = ready_reg;
        frames_next    = frames_reg;
        nused_next     = nused_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        for (int c = 0; c < esc_pkg::CHANNELS; c++)
        begin
            rel_next[c]      = rel_reg[c];
            walk_val_next[c] = walk_val_reg[c];
            walk_rel_next[c] = walk_rel_reg[c];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.accepted = 1'b0;
                    if (!q_data.is_load)
                    begin
                        // timer tick
                        tick_next = tick_inc;
                        for (int i = 0; i < esc_pkg::PIN_W; i++)
                        begin
                            if (pin_reg[i] && (tick_inc >= esc_pkg::TICK_W'(rel_reg[i])))
                            begin
                                pin_next[i] = 1'b0;
                            end
                        end
                        if (!ready_reg && (tick_inc >= cfg.frame_period))
                        begin
                            ready_next = 1'b1;
                        end
                    end
                    else if (ready_reg)
                    begin
                        // frame start
                        if (frames_dec == 8'd0)
                        begin
                            frames_next = cfg.servo_every;
                            pin_next    = (pin_reg | esc_pkg::PIN_MASK) & esc_pkg::PINS_EXIST;
                        end
                        else
                        begin
                            frames_next = frames_dec;
                            pin_next    = (pin_reg | (~cfg.servo_mask & esc_pkg::PIN_MASK))
                                          & esc_pkg::PINS_EXIST;
                        end
                        tick_next              = '0;
                        ready_next             = 1'b0;
                        out_word_next.accepted = 1'b1;
                        nused_next             = nused_cfg;
                        for (int c = 0; c < esc_pkg::CHANNELS; c++)
                        begin
                            walk_val_next[c] = q_data.vals[c];
                            walk_rel_next[c] = q_data.vals[c];
                        end
                        step_next  = '0;
                        state_next = ST_WALK;
                    end
                    out_word_next.pin_levels = pin_next;
                    out_word_next.ready_res  = ready_next;
                end
            end
            ST_WALK:
            begin
                if (step_reg == esc_pkg::STEP_W'(esc_pkg::WALK_STEPS))
                begin
                    // commit release times, unused pins mirror channel three or four
                    for (int c = 0; c < esc_pkg::CHANNELS; c++)
                    begin
                        if (esc_pkg::N_W'(c) < nused_reg)
                        begin
                            rel_next[c] = esc_pkg::rel_time(walk_rel_reg[c]);
                        end
                        else
                        begin
                            rel_next[c] = esc_pkg::rel_time(walk_rel_reg[(c >= 2) ? c - 2 : c]);
                        end
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    for (int c = 0; c < esc_pkg::CHANNELS; c++)
                    begin
                        walk_rel_next[c] = step_rel[c];
                    end
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            tick_reg      <= '0;
            pin_reg       <= '0;
            ready_reg     <= 1'b1;
            frames_reg    <= esc_pkg::RST_SERVO_EVERY;
            nused_reg     <= esc_pkg::MIN_USED;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            for (int c = 0; c < esc_pkg::CHANNELS; c++)
            begin
                rel_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tick_reg      <= tick_next;
            pin_reg       <= pin_next;
            ready_reg     <= ready_next;
            frames_reg    <= frames_next;
            nused_reg     <= nused_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            for (int c = 0; c < esc_pkg::CHANNELS; c++)
            begin
                rel_reg[c] <= rel_next[c];
            end
        end
    end

    // walk operands
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < esc_pkg::CHANNELS; c++)
        begin
            walk_val_reg[c] <= walk_val_next[c];
            walk_rel_reg[c] <= walk_rel_next[c];
        end
    end

endmodule

### src/multi_channel_esc_pulse_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_esc_pulse_generator
// Six-pin ESC/servo pulse generator: each word is a timer tick or a frame
// load, and each word returns one result word with the pin levels.
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word. A steady stream of tick
// words runs at one word per cycle while out_stall is low. An accepted
// load raises the pins and then holds the back part for five walk steps
// of the per-channel release logic plus one commit step before the next
// word is executed; a refused load does not hold the back part. A two-word
// queue sits between input and execution, and the result is held in an
// output register, so the input side keeps taking words while a result
// waits, until the queue is full. Configuration is written through
// cfg_valid/cfg_ready, which is always ready.
module multi_channel_esc_pulse_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  esc_pkg::in_word_t                     in_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output esc_pkg::out_word_t                    out_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    esc_pkg::cfg_t      cfg_reg, cfg_next;
    logic               q_full;
    logic               push_valid;
    esc_pkg::q_entry_t  push_data;
    logic               q_pop;
    logic               q_valid;
    esc_pkg::q_entry_t  q_data;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                esc_pkg::REG_FRAME_PERIOD: cfg_next.frame_period = cfg_data;
                esc_pkg::REG_SERVO_EVERY:  cfg_next.servo_every  = cfg_data[7:0];
                esc_pkg::REG_SERVO_MASK:   cfg_next.servo_mask   = cfg_data[esc_pkg::PIN_W-1:0];
                esc_pkg::REG_CHAN_COUNT:   cfg_next.chan_count   = cfg_data[2:0];
                esc_pkg::REG_MIN_GAP:      cfg_next.min_gap      = cfg_data[9:0];
                default:                   cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period <= esc_pkg::RST_FRAME_PERIOD;
            cfg_reg.servo_every  <= esc_pkg::RST_SERVO_EVERY;
            cfg_reg.servo_mask   <= esc_pkg::RST_SERVO_MASK;
            cfg_reg.chan_count   <= esc_pkg::RST_CHAN_COUNT;
            cfg_reg.min_gap      <= esc_pkg::RST_MIN_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify
    esc_front u_front (
        .in_word    (in_word),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // queue between front and back
    esc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    // back: execute ticks and loads
    esc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
